>>> hdl/oul_pkg.sv
// shared types and constants of the ordered unique value list
package oul_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int Q_DEPTH      = 2;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_LIST   = 3'd4;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_NOTFOUND  = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_EMPTY     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_LIST   = 3'd4,
        CMD_NOP    = 3'd5
    } t_kind;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value_in;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] value_out;
        logic [4:0]         entry_count;
        logic               last;
    } t_out_word;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
    } t_cmd;

endpackage

>>> hdl/oul_front.sv
// input stage: takes words and decodes the opcode into a command
module oul_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  oul_pkg::t_in_word i_in_word,
    output logic             o_cmd_push,
    output oul_pkg::t_cmd    o_cmd,
    input  logic             i_cmd_full
);
    import oul_pkg::*;

    logic  r_valid, n_valid;
    t_cmd  r_cmd;
    t_kind w_kind;
    logic  w_accept;

    assign o_in_stall = r_valid && i_cmd_full;
    assign o_cmd_push = r_valid && !i_cmd_full;
    assign o_cmd      = r_cmd;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (i_in_word.opcode)
            OP_CLEAR:  w_kind = CMD_CLEAR;
            OP_INSERT: w_kind = CMD_INSERT;
            OP_DELETE: w_kind = CMD_DELETE;
            OP_SEARCH: w_kind = CMD_SEARCH;
            OP_LIST:   w_kind = CMD_LIST;
            default:   w_kind = CMD_NOP;
        endcase
    end

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_cmd_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.kind  <= w_kind;
            r_cmd.value <= i_in_word.value_in;
        end
    end

endmodule

>>> hdl/oul_fifo.sv
// short command queue between the decode stage and the list engine
module oul_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  oul_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output oul_pkg::t_cmd o_head,
    input  logic          i_pop
);
    import oul_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);
    localparam logic [QCW-1:0] QFULL = QCW'(Q_DEPTH);
    localparam logic [QAW-1:0] QLAST = QAW'(Q_DEPTH - 1);

    t_cmd           r_buf [Q_DEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_cnt;
    logic           w_do_push, w_do_pop;

    assign o_full    = (r_cnt == QFULL);
    assign o_valid   = (r_cnt != '0);
    assign o_head    = r_buf[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == QLAST) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QLAST) ? '0 : r_rd_ptr + QAW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> hdl/oul_back.sv
// list engine: value store, scan, shift on delete, list readout and result register
module oul_back #(
    parameter int CAPACITY = oul_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  oul_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output oul_pkg::t_out_word o_out_word
);
    import oul_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_SHIFT    = 6'b000100,
        S_LIST_RD  = 6'b001000,
        S_LIST_OUT = 6'b010000,
        S_RESP     = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_kind       r_kind, n_kind;
    logic [31:0] r_value, n_value;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_cmp_idx, n_cmp_idx;
    logic        r_cmp_v, n_cmp_v;
    t_status     r_status, n_status;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word, n_out_word;

    logic [31:0] r_mem [CAPACITY];
    logic [31:0] r_rdata;

    logic          w_rd_en, w_wr_en;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [31:0]   w_wr_data;
    logic [CW-1:0] w_prev_idx, w_next_idx;
    logic          w_hit, w_out_free, w_list_last, w_scan_end;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_prev_idx  = r_cmp_idx - CW'(1);
    assign w_next_idx  = r_rd_idx + CW'(1);
    assign w_hit       = r_cmp_v && (r_rdata == r_value);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_list_last = (w_next_idx == r_count);
    assign w_scan_end  = !r_cmp_v && (r_rd_idx == r_count);

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_value     = r_value;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_v     = r_cmp_v;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        o_cmd_pop   = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_rd_idx[AW-1:0];
        w_wr_en     = 1'b0;
        w_wr_addr   = r_count[AW-1:0];
        w_wr_data   = r_value;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_kind    = i_cmd.kind;
                    n_value   = i_cmd.value;
                    n_rd_idx  = '0;
                    n_cmp_v   = 1'b0;
                    n_status  = STAT_OK;
                    unique case (i_cmd.kind)
                        CMD_INSERT, CMD_DELETE, CMD_SEARCH: begin
                            n_state = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_state = S_RESP;
                        end
                        CMD_LIST: begin
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_LIST_RD;
                            end
                        end
                        CMD_NOP: begin
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (w_hit) begin
                    n_cmp_v = 1'b0;
                    priority if (r_kind == CMD_SEARCH) begin
                        n_status = STAT_FOUND;
                        n_state  = S_RESP;
                    end else if (r_kind == CMD_INSERT) begin
                        n_status = STAT_DUPLICATE;
                        n_state  = S_RESP;
                    end else begin
                        // close the gap from the entry after the match
                        n_rd_idx = r_cmp_idx + CW'(1);
                        n_state  = S_SHIFT;
                    end
                end else if (w_scan_end) begin
                    n_state = S_RESP;
                    if (r_kind == CMD_INSERT) begin
                        if (r_count == CAP) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_wr_en = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else begin
                        n_status = STAT_NOTFOUND;
                    end
                end else if (r_rd_idx != r_count) begin
                    w_rd_en   = 1'b1;
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_rd_idx;
                    n_rd_idx  = w_next_idx;
                end else begin
                    n_cmp_v = 1'b0;
                end
            end

            S_SHIFT: begin
                if (r_cmp_v) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_prev_idx[AW-1:0];
                    w_wr_data = r_rdata;
                end
                if (w_scan_end) begin
                    n_count  = r_count - CW'(1);
                    n_status = STAT_OK;
                    n_state  = S_RESP;
                end else if (r_rd_idx != r_count) begin
                    w_rd_en   = 1'b1;
                    n_cmp_v   = 1'b1;
                    n_cmp_idx = r_rd_idx;
                    n_rd_idx  = w_next_idx;
                end else begin
                    n_cmp_v = 1'b0;
                end
            end

            S_LIST_RD: begin
                w_rd_en = 1'b1;
                n_state = S_LIST_OUT;
            end

            S_LIST_OUT: begin
                if (w_out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_word.status      = STAT_OK;
                    n_out_word.value_out   = r_rdata;
                    n_out_word.entry_count = 5'(r_count);
                    n_out_word.last        = w_list_last;
                    n_rd_idx               = w_next_idx;
                    n_state                = w_list_last ? S_IDLE : S_LIST_RD;
                end
            end

            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_word.status      = r_status;
                    n_out_word.value_out   = '0;
                    n_out_word.entry_count = 5'(r_count);
                    n_out_word.last        = 1'b1;
                    n_state                = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_v     <= n_cmp_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_value    <= n_value;
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_status   <= n_status;
        r_out_word <= n_out_word;
    end

    // value store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

endmodule

>>> hdl/ordered_unique_value_list_top.sv
// top level of the ordered unique value list
//
//   channel   direction  handshake                   word
//   request   in         i_in_valid / o_in_stall     i_in_word  (opcode, value_in)
//   result    out        o_out_valid / i_out_stall   o_out_word (status, value_out,
//                                                               entry_count, last)
//
// insert and search scan the store one entry per cycle through its single read port;
// a search or a duplicate ends the scan at the hit; delete moves the later entries
// down one per cycle in place of scanning them
// list returns one result word per stored value, in order; an empty list, clear and
// unused opcodes return a single result word
// a decode register and the command queue lie ahead of the engine
// reset is synchronous and active low: it empties the list and both queues at once
// the decode stage and a two-word command queue keep taking requests while the
// engine waits on a stalled result; the result register holds until taken
module ordered_unique_value_list_top #(
    parameter int CAPACITY = oul_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  oul_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output oul_pkg::t_out_word o_out_word
);
    import oul_pkg::*;

    // decoded command from the front end into the queue
    t_cmd w_front_cmd;
    logic w_front_push;
    logic w_q_full;

    // queue head into the engine
    t_cmd w_head_cmd;
    logic w_head_valid;
    logic w_head_pop;

    // request decode
    oul_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_cmd_push (w_front_push),
        .o_cmd      (w_front_cmd),
        .i_cmd_full (w_q_full)
    );

    // decouples decode from the engine
    oul_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .o_valid (w_head_valid),
        .o_head  (w_head_cmd),
        .i_pop   (w_head_pop)
    );

    // store, scan and result generation
    oul_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_head_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_head_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule
